### rtl/sfe_pkg.sv
`timescale 1ns / 1ps

package sfe_pkg;

  // First trial divisor of the square search.
  localparam int unsigned FIRST_DIVISOR = 2;

  // Output field widths.
  localparam int unsigned FACTOR_BITS    = 16;
  localparam int unsigned REMAINDER_BITS = 31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new radicand and set up the search
    logic div_init;  // start a division of m by i*i
    logic div_step;  // one restoring division step
    logic take;      // i*i divides m: m <= m / (i*i), k <= k * i
    logic advance;   // move on to the next trial divisor
    logic emit;      // present the result for one cycle
  } sfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sq_le_m;   // i*i does not exceed m
    logic div_last;  // the current division step is the last one
    logic rem_zero;  // the finished division left no remainder
  } sfe_status_t;

endpackage

### rtl/sfe_ctrl.sv
`timescale 1ns / 1ps

module sfe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  sfe_pkg::sfe_status_t status_i,
  output sfe_pkg::sfe_cmd_t    cmd_o,
  output logic                busy_o
);
  import sfe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_DIV    = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.sq_le_m) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // Divide out the same square again, or try the next divisor.
        if (status_i.rem_zero) begin
          cmd_o.take = 1'b1;
        end else begin
          cmd_o.advance = 1'b1;
        end
        state_d = S_CHECK;
      end
      S_DONE: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### rtl/sfe_datapath.sv
`timescale 1ns / 1ps

module sfe_datapath #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfe_pkg::sfe_cmd_t              cmd_i,
  output sfe_pkg::sfe_status_t           status_o,
  input  logic signed [VALUE_BITS-1:0]  value_i,
  output logic [sfe_pkg::FACTOR_BITS-1:0]    factor_o,
  output logic [sfe_pkg::REMAINDER_BITS-1:0] remainder_o,
  output logic                          is_perfect_o,
  output logic                          valid_o
);
  import sfe_pkg::*;

  localparam int unsigned W  = VALUE_BITS;
  localparam int unsigned IW = W / 2 + 1;
  localparam int unsigned CW = $clog2(W);
  localparam int unsigned FW = FACTOR_BITS;
  localparam int unsigned RW = REMAINDER_BITS;

  logic [W-1:0]  m_q, sq_q, rem_q, quo_q;
  logic [IW-1:0] i_q, k_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;

  logic [W:0]      trial;
  logic [W:0]      diff;
  logic [2*IW-1:0] prod;
  logic            in_neg, in_zero;
  logic [FW+IW-1:0] k_ext;
  logic [RW+W-1:0]  m_ext;

  assign in_neg  = value_i[W-1];
  assign in_zero = (value_i == '0);
  assign trial   = {rem_q, quo_q[W-1]};
  assign diff    = trial - {1'b0, sq_q};
  assign prod    = k_q * i_q;

  // Control state of the search.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      neg_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        neg_q <= in_neg;
      end
      if (cmd_i.div_init) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Search and divider registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      // Negative and zero inputs finish at once with m = 0.
      m_q  <= (in_neg || in_zero) ? '0 : W'(value_i);
      k_q  <= (in_neg || in_zero) ? '0 : IW'(1);
      i_q  <= IW'(FIRST_DIVISOR);
      sq_q <= W'(FIRST_DIVISOR * FIRST_DIVISOR);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= m_q;
    end else if (cmd_i.div_step) begin
      if (!diff[W]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
    if (cmd_i.take) begin
      m_q <= quo_q;
      k_q <= prod[IW-1:0];
    end
    if (cmd_i.advance) begin
      // (i+1)^2 = i^2 + 2i + 1
      i_q  <= i_q + IW'(1);
      sq_q <= sq_q + W'({i_q, 1'b0}) + W'(1);
    end
  end

  assign status_o.sq_le_m  = (sq_q <= m_q);
  assign status_o.div_last = (cnt_q == CW'(W - 1));
  assign status_o.rem_zero = (rem_q == '0);

  assign k_ext = {{FW{1'b0}}, k_q};
  assign m_ext = {{RW{1'b0}}, m_q};

  assign factor_o     = k_ext[FW-1:0];
  assign remainder_o  = m_ext[RW-1:0];
  assign is_perfect_o = !neg_q && (m_q <= W'(1));
  assign valid_o      = cmd_i.emit;

endmodule

### rtl/square_factor_extract_core.sv
`timescale 1ns / 1ps

// Square-free decomposition of a signed integer n into k*k*m by trial
// division with the squares i*i, i = 2, 3, ... while i*i does not exceed
// what is left of m. A transaction is taken when start is high and busy is
// low; busy then stays high until the result has been shown. The result
// (factor_o, remainder_o, is_perfect_o) is on the ports for exactly one
// cycle with valid_o high, and the receiver cannot hold it off, so it must
// capture it in that cycle. Negative inputs give 0, 0 with the flag clear;
// zero gives 0, 0 with the flag set. A trial division is made once for
// each divisor i with i*i not above the current m and once more each time
// i*i divides m out. The divisions use a restoring divider, which retires
// one quotient bit per cycle.

module square_factor_extract_core #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_BITS-1:0]  value_i,
  output logic [sfe_pkg::FACTOR_BITS-1:0]    factor_o,
  output logic [sfe_pkg::REMAINDER_BITS-1:0] remainder_o,
  output logic                          is_perfect_o,
  output logic                          valid_o
);
  import sfe_pkg::*;

  // Command and status groups between the controller and the datapath.
  sfe_cmd_t    cmd;
  sfe_status_t status;

  // The controller sequences checks, divisions and updates.
  sfe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // The datapath holds m, k, i, i*i and the shared divider.
  sfe_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (value_i),
    .factor_o     (factor_o),
    .remainder_o  (remainder_o),
    .is_perfect_o (is_perfect_o),
    .valid_o      (valid_o)
  );

endmodule
